>>> rtl/core/cbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types, format codes and the CP1252 upper-control table for the
// byte transcoder.
// ----------------------------------------------------------------------------
package cbt_pkg;

    // Source / target format codes (code three falls back to ISO-8859-1)
    localparam logic [1:0] FMT_ISO    = 2'd0;
    localparam logic [1:0] FMT_CP1252 = 2'd1;
    localparam logic [1:0] FMT_UTF16  = 2'd2;

    // Configuration register indexes
    localparam int         CFG_INDEX_W   = 1;
    localparam logic [0:0] CFG_IN_FORMAT  = 1'b0;
    localparam logic [0:0] CFG_OUT_FORMAT = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] QMARK = 8'h3F;

    // Code points for bytes 0x80-0x9F in CP1252
    localparam logic [15:0] CP_TABLE [32] = '{
        16'h20AC, 16'hFFFD, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'hFFFD, 16'h017D, 16'hFFFD,
        16'hFFFD, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'hFFFD, 16'h017E, 16'h0178
    };

    // One decoded code point on its way to the encoder
    typedef struct packed {
        logic [15:0] cp;
        logic        last;
    } cp_entry_t;

    function automatic logic [15:0] cp1252_decode(logic [7:0] b);
        logic [15:0] r;
        r = {8'h00, b};
        if (b >= 8'h80 && b <= 8'h9F) begin
            r = CP_TABLE[b[4:0]];
        end
        return r;
    endfunction

    // First table hit wins: scan downward so the lowest index is kept
    function automatic logic [7:0] cp1252_encode(logic [15:0] cp);
        logic [7:0] r;
        r = cp[7:0];
        if ((cp >= 16'h0080 && cp <= 16'h009F) || cp > 16'h00FF) begin
            r = QMARK;
            for (int i = 31; i >= 0; i--) begin
                if (CP_TABLE[i] == cp) begin
                    r = {3'b100, 5'(i)};
                end
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/cbt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_front
// Input side: accept source bytes, pair UTF-16 bytes, track the stopped
// state and push decoded code points into the queue.
// ----------------------------------------------------------------------------
module cbt_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         in_format,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    input  logic               s_in_last,
    input  logic               q_full,
    output logic               q_push,
    output cbt_pkg::cp_entry_t q_entry
);

    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic       stopped_reg, stopped_next;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        stopped_next    = stopped_reg;
        q_push          = 1'b0;
        q_entry.cp      = 16'h0000;
        q_entry.last    = s_in_last;
        if (accept) begin
            if (stopped_reg) begin
                // drop bytes until the buffer's last beat
                if (s_in_last) begin
                    stopped_next    = 1'b0;
                    held_valid_next = 1'b0;
                end
            end else begin
                if (in_format == cbt_pkg::FMT_UTF16) begin
                    if (held_valid_reg) begin
                        q_entry.cp      = {s_in_byte, held_byte_reg};
                        q_push          = 1'b1;
                        held_valid_next = 1'b0;
                    end else if (s_in_last) begin
                        q_push = 1'b1;  // lone final byte reads as zero
                    end else begin
                        held_byte_next  = s_in_byte;
                        held_valid_next = 1'b1;
                    end
                end else begin
                    held_valid_next = 1'b0;
                    if (in_format == cbt_pkg::FMT_CP1252) begin
                        q_entry.cp = cbt_pkg::cp1252_decode(s_in_byte);
                    end else begin
                        q_entry.cp = {8'h00, s_in_byte};
                    end
                    q_push = 1'b1;
                end
                if (q_push) begin
                    if (s_in_last) begin
                        stopped_next    = 1'b0;
                        held_valid_next = 1'b0;
                    end else if (q_entry.cp == 16'h0000) begin
                        stopped_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            stopped_reg    <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
            stopped_reg    <= stopped_next;
        end
        held_byte_reg <= held_byte_next;
    end

endmodule

>>> rtl/core/cbt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_queue
// Short register queue of decoded code points between front and back.
// ----------------------------------------------------------------------------
module cbt_queue #(
    parameter int DEPTH = cbt_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cbt_pkg::cp_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output cbt_pkg::cp_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cbt_pkg::cp_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/cbt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbt_back
// Output side: encode each code point and emit one or two result beats
// through an output register, with the UTF-16 high byte held pending.
// ----------------------------------------------------------------------------
module cbt_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         out_format,
    input  logic               q_not_empty,
    input  cbt_pkg::cp_entry_t q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_run_end,
    output logic               m_terminated,
    output logic               m_unterminated_end
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_end_reg, out_end_next;
    logic       out_term_reg, out_term_next;
    logic       out_unterm_reg, out_unterm_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       pend_term_reg, pend_term_next;
    logic       pend_unterm_reg, pend_unterm_next;
    logic       out_free;
    logic       is_zero;

    assign out_free = !out_valid_reg || m_ready;
    assign q_pop    = q_not_empty && !pend_valid_reg && out_free;
    assign is_zero  = (q_head.cp == 16'h0000);

    always_comb begin
        out_valid_next   = out_valid_reg && !m_ready;
        out_byte_next    = out_byte_reg;
        out_end_next     = out_end_reg;
        out_term_next    = out_term_reg;
        out_unterm_next  = out_unterm_reg;
        pend_valid_next  = pend_valid_reg;
        pend_byte_next   = pend_byte_reg;
        pend_term_next   = pend_term_reg;
        pend_unterm_next = pend_unterm_reg;
        if (out_free && pend_valid_reg) begin
            // send the held high byte
            out_valid_next  = 1'b1;
            out_byte_next   = pend_byte_reg;
            out_end_next    = 1'b1;
            out_term_next   = pend_term_reg;
            out_unterm_next = pend_unterm_reg;
            pend_valid_next = 1'b0;
        end else if (q_pop) begin
            out_valid_next  = 1'b1;
            out_term_next   = is_zero;
            out_unterm_next = q_head.last && !is_zero;
            out_end_next    = 1'b1;
            if (out_format == cbt_pkg::FMT_UTF16) begin
                out_byte_next    = q_head.cp[7:0];
                out_end_next     = 1'b0;
                pend_valid_next  = 1'b1;
                pend_byte_next   = q_head.cp[15:8];
                pend_term_next   = is_zero;
                pend_unterm_next = q_head.last && !is_zero;
            end else if (out_format == cbt_pkg::FMT_CP1252) begin
                out_byte_next = cbt_pkg::cp1252_encode(q_head.cp);
            end else begin
                out_byte_next = (q_head.cp > 16'h00FF) ? cbt_pkg::QMARK : q_head.cp[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
        out_byte_reg    <= out_byte_next;
        out_end_reg     <= out_end_next;
        out_term_reg    <= out_term_next;
        out_unterm_reg  <= out_unterm_next;
        pend_byte_reg   <= pend_byte_next;
        pend_term_reg   <= pend_term_next;
        pend_unterm_reg <= pend_unterm_next;
    end

    assign m_valid            = out_valid_reg;
    assign m_out_byte         = out_byte_reg;
    assign m_run_end          = out_end_reg;
    assign m_terminated       = out_term_reg;
    assign m_unterminated_end = out_unterm_reg;

endmodule

>>> rtl/core/charset_byte_transcoder_unit.sv
`timescale 1ns / 1ps
// Path: the first result beat of a byte passes through the queue slot and then the output register.
// Throughput: one input byte per cycle while the queue is not full; one output beat per cycle
//   from the single output register while m_ready is high, so an ISO-8859-1 or CP1252 source
//   into a UTF-16 target, which needs two beats per byte, is held back by the output side.
// Reset (aresetn low, synchronous): formats return to ISO-8859-1, the held UTF-16
//   byte and the stopped state clear, the queue and output register empty.
// ----------------------------------------------------------------------------
// charset_byte_transcoder_unit
// Byte-stream transcoder between ISO-8859-1, CP1252 and UTF-16LE. A front
// stage decodes source bytes into code points, a short queue decouples it
// from a back stage that encodes and emits the result beats.
// ----------------------------------------------------------------------------
module charset_byte_transcoder_unit #(
    parameter int QUEUE_DEPTH = cbt_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cbt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [1:0]                      cfg_data,
    // source bytes
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_in_byte,
    input  logic                            s_in_last,
    // converted bytes
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_out_byte,
    output logic                            m_run_end,
    output logic                            m_terminated,
    output logic                            m_unterminated_end
);

    logic [1:0]         in_format_reg;
    logic [1:0]         out_format_reg;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_not_empty;
    cbt_pkg::cp_entry_t q_in;
    cbt_pkg::cp_entry_t q_head;

    // Configuration is always accepted; the user must write it only while the datapath is idle, so that
    // no beat sees a format change mid-flight; the block itself does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_format_reg  <= cbt_pkg::FMT_ISO;
            out_format_reg <= cbt_pkg::FMT_ISO;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cbt_pkg::CFG_IN_FORMAT:  in_format_reg  <= cfg_data;
                cbt_pkg::CFG_OUT_FORMAT: out_format_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front: pair UTF-16 bytes, apply CP1252 decode, drop beats while stopped
    cbt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_format (in_format_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    // Queue: hold decoded code points so either side may stall alone
    cbt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // Back: encode and emit one beat (two for UTF-16) per code point
    cbt_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .out_format         (out_format_reg),
        .q_not_empty        (q_not_empty),
        .q_head             (q_head),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_byte         (m_out_byte),
        .m_run_end          (m_run_end),
        .m_terminated       (m_terminated),
        .m_unterminated_end (m_unterminated_end)
    );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - charset byte transcoder testbench
// Streams source bytes through the transcoder under directed and randomly chosen pairings of source
// and target format, predicts each converted beat in step with the source
// handshake and checks the output channel beat by beat against it. A short
// directed pass hits the table edges, UTF-16 pairing, lone final bytes and
// the string stop; a long random pass follows with bursty traffic on the
// source side, a stalling sink and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1250;

    localparam logic [7:0] QUESTION = 8'h3F;

    // Code points of CP1252 bytes 0x80..0x9F, entry 0 in the top slice
    localparam logic [16*32-1:0] CP1252_UPPER = {
        16'h20AC, 16'hFFFD, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'hFFFD, 16'h017D, 16'hFFFD,
        16'hFFFD, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'hFFFD, 16'h017E, 16'h0178
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } src_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       terminated;
        logic       unterminated_end;
    } beat_t;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #10 aclk = ~aclk;

    // Block ports; the inputs are all driven to known values from time zero
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_index = '0;
    logic [1:0] cfg_data  = '0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = '0;
    logic       s_in_last = 1'b0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_run_end;
    logic       m_terminated;
    logic       m_unterminated_end;

    charset_byte_transcoder_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_in_byte          (s_in_byte),
        .s_in_last          (s_in_last),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_byte         (m_out_byte),
        .m_run_end          (m_run_end),
        .m_terminated       (m_terminated),
        .m_unterminated_end (m_unterminated_end)
    );

    // Source bytes waiting for the driver, converted beats waiting for the sink
    src_item_t pending_bytes[$];
    beat_t     expected_beats[$];

    // Predictor copy of the formats and the conversion state
    logic [1:0] cur_in_fmt  = cbt_pkg::FMT_ISO;
    logic [1:0] cur_out_fmt = cbt_pkg::FMT_ISO;
    logic [7:0] held_byte    = '0;
    logic       held_valid   = 1'b0;
    logic       conv_stopped = 1'b0;

    int mismatch_count   = 0;
    int accepted_items   = 0;
    int beats_checked    = 0;
    int settings_written = 0;
    int random_items     = 0;
    int cycle_count      = 0;
    bit hold_request     = 1'b0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [15:0] cp1252_upper(input int idx);
        return CP1252_UPPER[(31 - idx)*16 +: 16];
    endfunction

    // Lowest table index wins; a code point in 0x80-0x9F or above 0xFF that the table lacks becomes a question mark
    function automatic logic [7:0] cp1252_byte(input logic [15:0] cp);
        logic [7:0] r;
        bit         found;
        r     = cp[7:0];
        found = 1'b0;
        if ((cp >= 16'h0080 && cp <= 16'h009F) || cp > 16'h00FF) begin
            r = QUESTION;
            for (int i = 0; i < 32; i++) begin
                if (!found && cp1252_upper(i) == cp) begin
                    r     = 8'h80 + 8'(i);
                    found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Advance the conversion state by one source byte and queue its beats
    function automatic void predict_transcode(input logic [7:0] b, input logic last);
        logic [15:0] cp;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        bit          two_beats;
        beat_t       beat;
        if (conv_stopped) begin
            // drop everything up to the end of the buffer
            if (last) begin
                conv_stopped = 1'b0;
                held_valid   = 1'b0;
                held_byte    = '0;
            end
            return;
        end
        if (cur_in_fmt == cbt_pkg::FMT_UTF16) begin
            if (held_valid) begin
                cp         = {b, held_byte};
                held_valid = 1'b0;
                held_byte  = '0;
            end else if (last) begin
                cp = '0;
            end else begin
                held_byte  = b;
                held_valid = 1'b1;
                return;
            end
        end else begin
            held_valid = 1'b0;
            held_byte  = '0;
            if (cur_in_fmt == cbt_pkg::FMT_CP1252 && b >= 8'h80 && b <= 8'h9F) begin
                cp = cp1252_upper(int'(b[4:0]));
            end else begin
                cp = {8'h00, b};
            end
        end
        second_byte = cp[15:8];
        two_beats   = 1'b0;
        if (cur_out_fmt == cbt_pkg::FMT_UTF16) begin
            first_byte = cp[7:0];
            two_beats  = 1'b1;
        end else if (cur_out_fmt == cbt_pkg::FMT_CP1252) begin
            first_byte = cp1252_byte(cp);
        end else begin
            first_byte = (cp > 16'h00FF) ? QUESTION : cp[7:0];
        end
        beat.terminated       = (cp == 16'h0000);
        beat.unterminated_end = last && (cp != 16'h0000);
        beat.out_byte         = first_byte;
        beat.run_end          = !two_beats;
        expected_beats.push_back(beat);
        if (two_beats) begin
            beat.out_byte = second_byte;
            beat.run_end  = 1'b1;
            expected_beats.push_back(beat);
        end
        if (last) begin
            conv_stopped = 1'b0;
            held_valid   = 1'b0;
            held_byte    = '0;
        end else if (cp == 16'h0000) begin
            conv_stopped = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Source driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin : source_driver
        bit        next_valid;
        bit        launch;
        int        gl;
        int        bl;
        src_item_t item;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            next_valid = s_valid;
            launch     = 1'b0;
            gl         = gap_left;
            bl         = burst_left;
            // predict on the accepting edge, then free the slot
            if (s_valid && s_ready) begin
                predict_transcode(s_in_byte, s_in_last);
                accepted_items++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_bytes.size() != 0) begin
                if (gl != 0) begin
                    gl--;
                end else begin
                    item       = pending_bytes.pop_front();
                    next_valid = 1'b1;
                    launch     = 1'b1;
                    // close the burst and pick the next gap; a zero gap chains bursts
                    if (bl <= 1) begin
                        bl = $urandom_range(1, 40);
                        gl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        bl--;
                    end
                end
            end
            // one assignment per signal per edge, so valid stays high across beats
            s_valid    <= next_valid;
            gap_left   <= gl;
            burst_left <= bl;
            if (launch) begin
                s_in_byte <= item.data;
                s_in_last <= item.last;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink ready: rotating stall patterns plus one long hold-off on request
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;
    bit hold_taken = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_mode <= 0;
            mode_left  <= 0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_request && !hold_taken) begin
            // start the long hold-off so the block backs up into the source side
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(32, 256);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_ready <= ~m_ready;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: compare each accepted beat with the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : output_monitor
        beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t ns: beat with nothing expected, expected none, actual %0h/%b%b%b",
                         $time, m_out_byte, m_run_end, m_terminated, m_unterminated_end);
                mismatch_count++;
            end else begin
                want = expected_beats.pop_front();
                check_field("out_byte", want.out_byte, m_out_byte);
                check_field("run_end", want.run_end, m_run_end);
                check_field("terminated", want.terminated, m_terminated);
                check_field("unterminated_end", want.unterminated_end, m_unterminated_end);
            end
            beats_checked++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d beats still expected", $time,
                     expected_beats.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [7:0] data, input logic last);
        src_item_t item;
        item.data = data;
        item.last = last;
        pending_bytes.push_back(item);
    endtask

    // Write one register; hold valid until the handshake, then mirror it
    task automatic write_reg(input logic [0:0] idx, input logic [1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == cbt_pkg::CFG_IN_FORMAT) begin
            cur_in_fmt = val;
        end else begin
            cur_out_fmt = val;
        end
        settings_written++;
    endtask

    task automatic set_formats(input logic [1:0] in_fmt, input logic [1:0] out_fmt);
        write_reg(cbt_pkg::CFG_IN_FORMAT, in_fmt);
        write_reg(cbt_pkg::CFG_OUT_FORMAT, out_fmt);
        @(negedge aclk);
    endtask

    // Wait until every byte is sent and every beat is back, then let held
    // bytes and dropped items clear the pipeline
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_bytes.size() != 0 || s_valid || expected_beats.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Mostly nonzero, often in the CP1252 upper-control range, rarely zero
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 199);
        if (r < 3) begin
            return 8'h00;
        end else if (r < 60) begin
            return 8'h80 + 8'($urandom_range(0, 31));
        end
        return 8'($urandom_range(1, 255));
    endfunction

    // Code points that hit the CP1252 table, the Latin-1 range or neither
    function automatic logic [15:0] pick_code_point();
        int r;
        r = $urandom_range(0, 199);
        if (r < 3) begin
            return 16'h0000;
        end else if (r < 70) begin
            return cp1252_upper($urandom_range(0, 31));
        end else if (r < 120) begin
            return 16'($urandom_range(1, 255));
        end
        return 16'($urandom_range(1, 16'hFFFF));
    endfunction

    // Mostly well-formed buffers ending in last, some loose noise
    task automatic gen_random_phase(input int budget);
        int          pushed;
        int          len;
        int          i;
        logic [15:0] cp;
        pushed = 0;
        while (pushed < budget) begin
            len = $urandom_range(1, 10);
            if ($urandom_range(0, 99) < 85) begin
                if (cur_in_fmt == cbt_pkg::FMT_UTF16) begin
                    for (i = 0; i < len; i++) begin
                        cp = pick_code_point();
                        push_item(cp[7:0], 1'b0);
                        push_item(cp[15:8], i == len - 1);
                    end
                    pushed += 2*len;
                end else begin
                    len = $urandom_range(1, 20);
                    for (i = 0; i < len; i++) begin
                        push_item(pick_byte(), i == len - 1);
                    end
                    pushed += len;
                end
            end else begin
                // odd lengths and stray last flags break UTF-16 pairing
                for (i = 0; i < len; i++) begin
                    push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
                pushed += len;
            end
        end
        random_items += pushed;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int phase;
        int budget;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Latin-1 straight through, including the top of the byte range
        set_formats(cbt_pkg::FMT_ISO, cbt_pkg::FMT_ISO);
        push_item(8'h41, 1'b0); push_item(8'hFF, 1'b0); push_item(8'h80, 1'b1);
        wait_idle();

        // CP1252 table edges to UTF-16; a zero ends the string and the rest is dropped
        set_formats(cbt_pkg::FMT_CP1252, cbt_pkg::FMT_UTF16);
        push_item(8'h80, 1'b0); push_item(8'h9F, 1'b0); push_item(8'h81, 1'b0);
        push_item(8'h7F, 1'b0); push_item(8'h00, 1'b0); push_item(8'h55, 1'b0);
        push_item(8'h66, 1'b1);
        wait_idle();

        // UTF-16 pairs into CP1252: replacement char, first and last table entry,
        // an unmapped code point, then a lone final byte
        set_formats(cbt_pkg::FMT_UTF16, cbt_pkg::FMT_CP1252);
        push_item(8'hFD, 1'b0); push_item(8'hFF, 1'b0);
        push_item(8'hAC, 1'b0); push_item(8'h20, 1'b0);
        push_item(8'h78, 1'b0); push_item(8'h01, 1'b0);
        push_item(8'h00, 1'b0); push_item(8'h30, 1'b0);
        push_item(8'h41, 1'b1);
        wait_idle();

        // UTF-16 into Latin-1: wide code point and a last beat without a zero;
        // leave a first byte held across the next format change
        set_formats(cbt_pkg::FMT_UTF16, cbt_pkg::FMT_ISO);
        push_item(8'h34, 1'b0); push_item(8'h12, 1'b0);
        push_item(8'hE9, 1'b0); push_item(8'h00, 1'b1);
        push_item(8'h77, 1'b0);
        wait_idle();

        // Format code three falls back to Latin-1 and discards the held byte
        set_formats(2'd3, 2'd3);
        push_item(8'h9F, 1'b1);
        wait_idle();

        // Random phases, each under a fresh pair of formats
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            set_formats(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            budget = (phase == 1) ? 200 : $urandom_range(60, 160);
            gen_random_phase(budget);
            // hold off the sink while this phase's bytes are still queued
            if (phase == 1) begin
                hold_request = 1'b1;
            end
            wait_idle();
            phase++;
        end

        $display("Run covered %0d source bytes (%0d random) over %0d register writes,",
                 accepted_items, random_items, settings_written);
        $display("with %0d converted beats checked and one long sink hold-off.",
                 beats_checked);
        if (mismatch_count == 0 && expected_beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/cbt_pkg.sv
rtl/core/cbt_front.sv
rtl/core/cbt_queue.sv
rtl/core/cbt_back.sv
rtl/core/charset_byte_transcoder_unit.sv
sim/tb.sv
